// ----- rtl/dvr_pkg.sv -----
`default_nettype none

package dvr_pkg;

    parameter int NODE_COUNT = 64;
    parameter int ADDR_W     = $clog2(NODE_COUNT);
    parameter int ID_W       = 6;
    parameter int LINK_W     = 8;
    parameter int HOPS_W     = 8;
    parameter int VER_W      = 32;
    parameter int PADDR_W    = 3;
    parameter int PDATA_W    = 32;

    localparam logic REQ_ENTRY       = 1'b0;
    localparam logic REQ_LOOKUP      = 1'b1;
    localparam logic RESULT_LOOKUP   = 1'b0;
    localparam logic RESULT_ANNOUNCE = 1'b1;
    localparam logic REG_OWN_NODE_ID = 1'b0;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   sender_id;
        logic [VER_W-1:0]  sender_version;
        logic [LINK_W-1:0] arrival_link;
        logic [ID_W-1:0]   entry_dst;
        logic [HOPS_W-1:0] entry_hops;
        logic              first_entry;
        logic              last_entry;
    } req_t;

    typedef struct packed {
        logic              result_kind;
        logic              route_valid;
        logic [LINK_W-1:0] route_link;
        logic [HOPS_W-1:0] route_hops;
        logic [VER_W-1:0]  new_version;
    } rsp_t;

    typedef struct packed {
        logic [HOPS_W-1:0] hop_cnt;
        logic [LINK_W-1:0] next_link;
    } route_entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/distance_vector_route_update_unit.sv -----
// Distance-vector route table.
// req channel (valid/ready): one item per vector entry (req_type 0), sent first
// to last, or a route lookup (req_type 1) for entry_dst.
// rsp channel (valid/ready): a lookup answer for every lookup, and one
// broadcast announcement after the last entry of a vector that changed the table.
// Each item is read and then written back: the accept edge issues reads of the route RAM
// (by destination) and the version RAM (by sender); the execute state then writes back
// and loads the result register, once no result is pending or rsp_ready is high.
// One item is in flight at a time; the next is accepted only after that write-back.
// rsp_valid rises at the commit edge of a lookup or of an announcing last entry.
// Reset clears the route present bits, the sender-version seen bits, the own
// version, the vector progress flags and own_node_id; RAM contents are not cleared.
// If rsp_ready stays low with a result pending, one more item may be accepted;
// it then waits in the execute stage until the result register frees.
// own_node_id is written through the APB port at address 0.
`default_nettype none

module distance_vector_route_update_unit
    import dvr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire req_t               req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rsp_t                    rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    state_t            state_reg, state_next;
    req_t              item_reg;
    logic [NODE_COUNT-1:0] present_reg, present_next;
    logic [NODE_COUNT-1:0] ver_seen_reg, ver_seen_next;
    logic [VER_W-1:0]  own_version_reg, own_version_next;
    logic              vec_acc_reg, vec_acc_next;
    logic              changed_reg, changed_next;
    logic [ID_W-1:0]   own_node_id_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg, rsp_next;

    logic              accept;
    logic              commit;
    logic              load_rsp;

    route_entry_t      route_rdata;
    route_entry_t      route_wdata;
    logic [LINK_W+HOPS_W-1:0] route_rdata_raw;
    logic              route_we;
    logic [VER_W-1:0]  ver_rdata;
    logic              ver_we;

    logic [ADDR_W-1:0] dst_idx;
    logic [ADDR_W-1:0] snd_idx;
    logic              is_entry;
    logic              dst_ok;
    logic              snd_ok;
    logic              present;
    logic [VER_W-1:0]  stored_ver;
    logic              newer;
    logic              acc;
    logic              chg_base;
    logic [HOPS_W-1:0] new_hops;
    logic              upd;
    logic              emit;

    // APB
    assign pready = 1'b1;
    assign prdata = {{(PDATA_W-ID_W){1'b0}}, own_node_id_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_id_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_OWN_NODE_ID)
        begin
            own_node_id_reg <= pwdata[ID_W-1:0];
        end
    end

    // Memories
    assign route_rdata = route_entry_t'(route_rdata_raw);

    dvr_ram #(
        .WIDTH (LINK_W + HOPS_W),
        .DEPTH (NODE_COUNT)
    ) u_route_ram (
        .clk   (clk),
        .we    (route_we),
        .waddr (dst_idx),
        .wdata (route_wdata),
        .re    (accept),
        .raddr (req.entry_dst[ADDR_W-1:0]),
        .rdata (route_rdata_raw)
    );

    dvr_ram #(
        .WIDTH (VER_W),
        .DEPTH (NODE_COUNT)
    ) u_ver_ram (
        .clk   (clk),
        .we    (ver_we),
        .waddr (snd_idx),
        .wdata (item_reg.sender_version),
        .re    (accept),
        .raddr (req.sender_id[ADDR_W-1:0]),
        .rdata (ver_rdata)
    );

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req_ready = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_EXEC:
            begin
                commit = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign accept = req_valid && req_ready;

    // Update datapath
    always_comb
    begin
        dst_idx    = item_reg.entry_dst[ADDR_W-1:0];
        snd_idx    = item_reg.sender_id[ADDR_W-1:0];
        is_entry   = item_reg.req_type == REQ_ENTRY;
        dst_ok     = 32'(item_reg.entry_dst) < 32'(NODE_COUNT);
        snd_ok     = 32'(item_reg.sender_id) < 32'(NODE_COUNT);
        present    = dst_ok && present_reg[dst_idx];
        stored_ver = ver_seen_reg[snd_idx] ? ver_rdata : '0;
        newer      = snd_ok && (stored_ver < item_reg.sender_version);
        acc        = item_reg.first_entry ? newer : vec_acc_reg;
        chg_base   = item_reg.first_entry ? 1'b0 : changed_reg;
        new_hops   = (item_reg.entry_hops == {HOPS_W{1'b1}}) ? item_reg.entry_hops
                                                              : item_reg.entry_hops + 1'b1;
        upd        = is_entry && acc && dst_ok && (item_reg.entry_dst != own_node_id_reg)
                     && (!present || route_rdata.hop_cnt > new_hops);
        emit       = is_entry && item_reg.last_entry && acc && (chg_base || upd);

        route_wdata.hop_cnt   = new_hops;
        route_wdata.next_link = item_reg.arrival_link;
        route_we = commit && upd;
        ver_we   = commit && is_entry && item_reg.first_entry && newer;

        present_next = present_reg;
        if (route_we)
        begin
            present_next[dst_idx] = 1'b1;
        end
        ver_seen_next = ver_seen_reg;
        if (ver_we)
        begin
            ver_seen_next[snd_idx] = 1'b1;
        end

        vec_acc_next = vec_acc_reg;
        changed_next = changed_reg;
        if (is_entry)
        begin
            if (item_reg.last_entry)
            begin
                vec_acc_next = 1'b0;
                changed_next = 1'b0;
            end
            else
            begin
                vec_acc_next = acc;
                changed_next = chg_base || upd;
            end
        end

        own_version_next = emit ? own_version_reg + 1'b1 : own_version_reg;

        rsp_next = '0;
        if (is_entry)
        begin
            rsp_next.result_kind = RESULT_ANNOUNCE;
            rsp_next.new_version = own_version_next;
        end
        else
        begin
            rsp_next.result_kind = RESULT_LOOKUP;
            rsp_next.route_valid = present;
            if (present)
            begin
                rsp_next.route_link = route_rdata.next_link;
                rsp_next.route_hops = route_rdata.hop_cnt;
            end
        end
        load_rsp = commit && (!is_entry || emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            present_reg     <= '0;
            ver_seen_reg    <= '0;
            own_version_reg <= '0;
            vec_acc_reg     <= 1'b0;
            changed_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                present_reg     <= present_next;
                ver_seen_reg    <= ver_seen_next;
                own_version_reg <= own_version_next;
                vec_acc_reg     <= vec_acc_next;
                changed_reg     <= changed_next;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/dvr_ram.sv -----
`default_nettype none

module dvr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- test/tb_distance_vector_route_update_unit.sv -----
`timescale 1ns / 100ps

module tb_distance_vector_route_update_unit
    import dvr_pkg::*;
();

    localparam int STALL_LIMIT = 4000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    distance_vector_route_update_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predicted route table
    logic              route_present [NODE_COUNT];
    logic [HOPS_W-1:0] route_hops_tbl [NODE_COUNT];
    logic [LINK_W-1:0] route_link_tbl [NODE_COUNT];
    logic [VER_W-1:0]  peer_version [NODE_COUNT];
    logic [VER_W-1:0]  table_version = '0;
    logic              vector_ok = 1'b0;
    logic              vector_changed = 1'b0;
    logic [ID_W-1:0]   my_node_id = '0;

    // versions as the stimulus generator expects them to be stored
    logic [VER_W-1:0]  sent_version [NODE_COUNT];

    req_t  pending_reqs [$];
    rsp_t  expected_answers [$];
    rsp_t  exp_answer;

    int send_idle_pct = 6;
    int recv_idle_pct = 70;
    int phase_items = 0;
    int items_accepted = 0;
    int lookups_checked = 0;
    int announces_checked = 0;
    int id_writes = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    initial begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            route_present[i] = 1'b0;
            route_hops_tbl[i] = '0;
            route_link_tbl[i] = '0;
            peer_version[i] = '0;
            sent_version[i] = '0;
        end
    end

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic void update_route_table(input req_t it);
        rsp_t       ans;
        logic [8:0] new_hops;
        logic       emit;
        ans = '0;
        if (it.req_type == REQ_LOOKUP)
        begin
            ans.result_kind = RESULT_LOOKUP;
            if (int'(it.entry_dst) < NODE_COUNT && route_present[it.entry_dst])
            begin
                ans.route_valid = 1'b1;
                ans.route_link  = route_link_tbl[it.entry_dst];
                ans.route_hops  = route_hops_tbl[it.entry_dst];
            end
            expected_answers.insert(expected_answers.size(), ans);
            return;
        end
        if (it.first_entry)
        begin
            vector_changed = 1'b0;
            vector_ok = int'(it.sender_id) < NODE_COUNT
                        && peer_version[it.sender_id] < it.sender_version;
            if (vector_ok)
                peer_version[it.sender_id] = it.sender_version;
        end
        if (vector_ok && it.entry_dst != my_node_id && int'(it.entry_dst) < NODE_COUNT)
        begin
            new_hops = {1'b0, it.entry_hops} + 9'd1;
            if (new_hops > 9'd255)
                new_hops = 9'd255;
            if (!route_present[it.entry_dst]
                || {1'b0, route_hops_tbl[it.entry_dst]} > new_hops)
            begin
                route_present[it.entry_dst] = 1'b1;
                route_hops_tbl[it.entry_dst] = new_hops[7:0];
                route_link_tbl[it.entry_dst] = it.arrival_link;
                vector_changed = 1'b1;
            end
        end
        if (it.last_entry)
        begin
            emit = vector_ok && vector_changed;
            vector_ok = 1'b0;
            vector_changed = 1'b0;
            if (emit)
            begin
                table_version = table_version + 1'b1;
                ans.result_kind = RESULT_ANNOUNCE;
                ans.new_version = table_version;
                expected_answers.insert(expected_answers.size(), ans);
            end
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic drive;
        req_t next_req;
        drive = req_valid;
        next_req = req;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                update_route_table(req);
                items_accepted++;
                drive = 1'b0;
            end
            if (!drive && pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                drive = 1'b1;
            end
        end
        req_valid <= drive;
        req <= next_req;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d valid %0d link %0d hops %0d ver %0d",
                                 rsp.result_kind, rsp.route_valid, rsp.route_link,
                                 rsp.route_hops, rsp.new_version);
                end
                else
                begin
                    exp_answer = expected_answers.pop_front();
                    if (rsp.result_kind !== exp_answer.result_kind
                        || rsp.route_valid !== exp_answer.route_valid
                        || rsp.route_link !== exp_answer.route_link
                        || rsp.route_hops !== exp_answer.route_hops
                        || rsp.new_version !== exp_answer.new_version)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                     exp_answer.result_kind, exp_answer.route_valid,
                                     exp_answer.route_link, exp_answer.route_hops,
                                     exp_answer.new_version, rsp.result_kind, rsp.route_valid,
                                     rsp.route_link, rsp.route_hops, rsp.new_version);
                    end
                    if (exp_answer.result_kind == RESULT_ANNOUNCE)
                        announces_checked++;
                    else
                        lookups_checked++;
                end
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (pending_reqs.size() == 0 && !req_valid && expected_answers.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_answers.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_node_id(input logic [ID_W-1:0] id);
        logic [PDATA_W-1:0] data;
        data = $urandom();
        data[ID_W-1:0] = id;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_OWN_NODE_ID) << 2;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        my_node_id = id;
        id_writes++;
    endtask

    task automatic queue_item(input req_t it);
        pending_reqs.insert(pending_reqs.size(), it);
        phase_items++;
        if (phase_items % 37 == 0)
            wait_for_quiet();
    endtask

    task automatic queue_entry(input logic [ID_W-1:0] sender, input logic [VER_W-1:0] ver,
                               input logic [LINK_W-1:0] link, input logic [ID_W-1:0] dst,
                               input logic [HOPS_W-1:0] hops, input logic first,
                               input logic last);
        req_t it;
        it.req_type       = REQ_ENTRY;
        it.sender_id      = sender;
        it.sender_version = ver;
        it.arrival_link   = link;
        it.entry_dst      = dst;
        it.entry_hops     = hops;
        it.first_entry    = first;
        it.last_entry     = last;
        if (first && ver > sent_version[sender])
            sent_version[sender] = ver;
        queue_item(it);
    endtask

    function automatic req_t random_req();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(req_t)-1:0];
    endfunction

    task automatic queue_lookup(input logic [ID_W-1:0] dst);
        req_t it;
        it = random_req();
        it.req_type = REQ_LOOKUP;
        it.entry_dst = dst;
        queue_item(it);
    endtask

    task automatic queue_noise();
        req_t it;
        it = random_req();
        queue_entry(it.sender_id, it.sender_version, it.arrival_link, it.entry_dst,
                    it.entry_hops, it.first_entry, it.last_entry);
    endtask

    task automatic queue_vector();
        logic [ID_W-1:0]   sender;
        logic [VER_W-1:0]  ver;
        logic [LINK_W-1:0] link;
        logic [ID_W-1:0]   dst;
        logic [HOPS_W-1:0] hops;
        int                len;
        int                pick;
        sender = ID_W'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
            ver = sent_version[sender] - $urandom_range(0, 2);
        else
            ver = sent_version[sender] + $urandom_range(1, 1000);
        link = LINK_W'($urandom_range(0, 255));
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < 15)
                queue_lookup(ID_W'($urandom_range(0, 63)));
            dst = ($urandom_range(0, 4) == 0) ? my_node_id : ID_W'($urandom_range(0, 63));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                hops = HOPS_W'($urandom_range(0, 12));
            else if (pick < 9)
                hops = HOPS_W'($urandom_range(0, 255));
            else
                hops = HOPS_W'($urandom_range(254, 255));
            queue_entry(sender, ver, link, dst, hops, i == 0, i == len - 1);
        end
    endtask

    task automatic run_random_phase(input int count);
        int pick;
        phase_items = 0;
        while (phase_items < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                queue_vector();
            else if (pick < 85)
                queue_lookup(ID_W'($urandom_range(0, 63)));
            else
                queue_noise();
        end
        wait_for_quiet();
    endtask

    initial begin : main
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_node_id(6'd5);
        phase_items = 0;
        queue_lookup(6'd0);
        // newest possible version, saturation and own-id skip, lookup mid-vector
        queue_entry(6'd63, 32'hFFFF_FFFF, 8'hFF, 6'd63, 8'd255, 1'b1, 1'b0);
        queue_entry(6'd63, 32'hFFFF_FFFF, 8'hFF, 6'd0, 8'd0, 1'b0, 1'b0);
        queue_lookup(6'd63);
        queue_entry(6'd63, 32'hFFFF_FFFF, 8'hFF, 6'd5, 8'd3, 1'b0, 1'b0);
        queue_entry(6'd63, 32'hFFFF_FFFF, 8'hFF, 6'd10, 8'd254, 1'b0, 1'b1);
        // same version again: dropped
        queue_entry(6'd63, 32'hFFFF_FFFF, 8'h00, 6'd20, 8'd0, 1'b1, 1'b1);
        queue_entry(6'd0, 32'd0, 8'h00, 6'd21, 8'd0, 1'b1, 1'b1);
        // equal hops kept, then entry without first mark improves
        queue_entry(6'd0, 32'd1, 8'h00, 6'd10, 8'd254, 1'b1, 1'b0);
        queue_entry(6'd0, 32'd1, 8'h00, 6'd10, 8'd100, 1'b0, 1'b1);
        queue_lookup(6'd10);
        queue_lookup(6'd63);
        queue_lookup(6'd0);
        queue_lookup(6'd5);
        queue_entry(6'd1, 32'd7, 8'h5A, 6'd0, 8'd0, 1'b1, 1'b1);
        // first entry restarts an open vector
        queue_entry(6'd2, 32'd1, 8'h11, 6'd30, 8'd4, 1'b1, 1'b0);
        queue_entry(6'd3, 32'd1, 8'h22, 6'd31, 8'd2, 1'b1, 1'b1);
        // entry after a closed vector is ignored
        queue_entry(6'd3, 32'd1, 8'h33, 6'd40, 8'd0, 1'b0, 1'b1);
        queue_lookup(6'd30);
        queue_lookup(6'd31);
        queue_lookup(6'd40);
        wait_for_quiet();

        write_node_id(6'd63);
        run_random_phase(150);

        send_idle_pct = 70;
        recv_idle_pct = 6;
        write_node_id(6'd0);
        run_random_phase(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_node_id(ID_W'($urandom_range(1, 62)));
        run_random_phase(150);

        repeat (10) @(posedge clk);
        $display("%0d items in, %0d lookup answers and %0d announcements checked",
                 items_accepted, lookups_checked, announces_checked);
        $display("%0d node id writes, %0d mismatches, %0d results missing",
                 id_writes, mismatches, expected_answers.size());
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
